[hdl/assert_macros.svh]
// assertion macros shared by the key=value validator rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, ignored while reset is high
`define KVTV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also during reset
`define KVTV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVTV_ASSERT(lbl, clk, rst, prop, msg)
`define KVTV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/kvtv_pkg.sv]
// types, codes and constants of the key=value text validator
// no dependencies
package kvtv_pkg;

  localparam logic [7:0] SEP_CHAR = 8'h3D;
  localparam logic [7:0] LINE_END = 8'h0A;
  localparam logic [7:0] CMT_CHAR = 8'h23;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_KEY_LEN   = 3'd2;
  localparam logic [2:0] ST_EMPTY_VAL = 3'd3;
  localparam logic [2:0] ST_COMMENT   = 3'd4;
  localparam logic [2:0] ST_NONPRINT  = 3'd5;
  localparam logic [2:0] ST_MISMATCH  = 3'd6;

  localparam logic CFG_MAX_FILE_BYTES = 1'b0;
  localparam logic CFG_MAX_KEY_LENGTH = 1'b1;

  localparam logic [15:0] MAX_FILE_BYTES_RST = 16'd4096;
  localparam logic [7:0]  MAX_KEY_LENGTH_RST = 8'd32;

  localparam logic [16:0] BYTE_COUNT_TOP  = 17'h1FFFF;
  localparam logic [8:0]  FIELD_LEN_TOP   = 9'h1FF;
  localparam logic [15:0] COUNT_TOP       = 16'hFFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } kvtv_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pair_total;
  } kvtv_out_t;

  typedef struct packed {
    logic [15:0] max_file_bytes;
    logic [7:0]  max_key_length;
  } kvtv_cfg_t;

  typedef struct packed {
    logic [16:0] byte_count;
    logic [8:0]  field_length;
    logic [15:0] separator_count;
    logic [15:0] pair_count;
    logic        in_comment;
    logic [2:0]  error_code;
  } kvtv_state_t;

endpackage

[hdl/kvtv_cfg.sv]
// limit registers of the key=value validator, written through a plain port
// depends on kvtv_pkg
module kvtv_cfg
  import kvtv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output kvtv_cfg_t   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_file_bytes <= MAX_FILE_BYTES_RST;
      cfg.max_key_length <= MAX_KEY_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_FILE_BYTES: cfg.max_file_bytes <= cfg_data;
        CFG_MAX_KEY_LENGTH: cfg.max_key_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/kvtv_scan.sv]
// per-byte next-state and verdict logic of the key=value validator
// depends on kvtv_pkg
module kvtv_scan
  import kvtv_pkg::*;
(
  input  kvtv_state_t st,
  input  kvtv_in_t    word,
  input  kvtv_cfg_t   cfg,
  output kvtv_state_t st_next,
  output kvtv_out_t   result
);

  kvtv_state_t upd;

  always_comb begin
    upd = st;
    upd.byte_count = (st.byte_count < BYTE_COUNT_TOP) ? st.byte_count + 17'd1 : BYTE_COUNT_TOP;
    if (st.error_code == ST_OK) begin
      case (word.text_byte)
        SEP_CHAR: begin
          upd.separator_count = (st.separator_count < COUNT_TOP) ?
                                st.separator_count + 16'd1 : COUNT_TOP;
          if (st.field_length == 9'd0 || st.field_length > {1'b0, cfg.max_key_length}) begin
            upd.error_code = ST_KEY_LEN;
          end else begin
            upd.field_length = 9'd0;
          end
        end
        LINE_END: begin
          if (!st.in_comment) begin
            upd.pair_count = (st.pair_count < COUNT_TOP) ? st.pair_count + 16'd1 : COUNT_TOP;
            if (st.field_length == 9'd0) begin
              upd.error_code = ST_EMPTY_VAL;
            end
          end
          // empty value case leaves these already clear
          upd.in_comment   = 1'b0;
          upd.field_length = 9'd0;
        end
        CMT_CHAR: begin
          if (!st.in_comment) begin
            upd.in_comment = 1'b1;
            if (st.field_length != 9'd0) begin
              upd.error_code = ST_COMMENT;
            end
          end
        end
        default: begin
          if (word.text_byte inside {[PRINT_LO:PRINT_HI]}) begin
            upd.field_length = (st.field_length < FIELD_LEN_TOP) ?
                               st.field_length + 9'd1 : FIELD_LEN_TOP;
          end else begin
            upd.error_code = ST_NONPRINT;
          end
        end
      endcase
    end
  end

  // verdict, size check first
  always_comb begin
    result.pair_total = 16'd0;
    if (upd.byte_count > {1'b0, cfg.max_file_bytes}) begin
      result.status = ST_TOO_LARGE;
    end else if (upd.error_code != ST_OK) begin
      result.status = upd.error_code;
    end else if (upd.separator_count != upd.pair_count) begin
      result.status = ST_MISMATCH;
    end else begin
      result.status     = ST_OK;
      result.pair_total = upd.pair_count;
    end
  end

  // last byte of a file clears all per-file state
  assign st_next = word.is_last ? '0 : upd;

endmodule

[hdl/kvtv_track.sv]
// per-file state registers of the key=value validator with their update logic
// depends on kvtv_pkg, kvtv_scan and assert_macros.svh
`include "assert_macros.svh"
module kvtv_track
  import kvtv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  kvtv_in_t  word,
  input  kvtv_cfg_t cfg,
  output kvtv_out_t result
);

  kvtv_state_t st;
  kvtv_state_t st_next;

  kvtv_scan u_scan (
    .st      (st),
    .word    (word),
    .cfg     (cfg),
    .st_next (st_next),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // first error holds until the file ends
  `KVTV_ASSERT(a_err_latched, clk, rst, (st.error_code != ST_OK && !(advance && word.is_last)) |=> $stable(st.error_code), "latched error changed")
  // after an error only the byte count moves
  `KVTV_ASSERT(a_err_freeze, clk, rst, (st.error_code != ST_OK && advance && !word.is_last) |=> ($stable(st.separator_count) && $stable(st.pair_count) && $stable(st.field_length)), "counters moved after error")
  // end of file leaves a clean state
  `KVTV_ASSERT(a_file_clear, clk, rst, (advance && word.is_last) |=> (st.byte_count == 17'd0 && st.error_code == ST_OK && !st.in_comment), "state not cleared at end of file")

endmodule

[hdl/key_value_text_validator.sv]
// top level of the key=value text validator: input stage, result register
// depends on kvtv_pkg, kvtv_cfg, kvtv_track and assert_macros.svh
//
//  channel | signals                         | direction | word
//  --------+---------------------------------+-----------+---------------------------
//  in      | in_valid, in_stall, in_word     | to block  | text_byte, is_last
//  out     | out_valid, out_stall, out_word  | from block| status, pair_total
//  cfg     | cfg_we, cfg_index, cfg_data     | to block  | limit register write
//
// one byte is taken every cycle unless in_stall is high; the result word of a file
// is valid once its last byte leaves the input register through the per-byte
// state update into the result register
// rst (synchronous) clears both stages, the per-file counters and restores
// the limits to 4096 bytes and 32 key characters
// a stalled result holds only the last byte of the next file back; other
// bytes keep flowing into the per-file state while the result waits
`include "assert_macros.svh"
module key_value_text_validator
  import kvtv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  kvtv_in_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output kvtv_out_t   out_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  kvtv_cfg_t cfg;
  kvtv_in_t  s1_word;
  logic      s1_valid;
  logic      out_free;
  logic      advance;
  kvtv_out_t result;

  kvtv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kvtv_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .word    (s1_word),
    .cfg     (cfg),
    .result  (result)
  );

  // result register can take a new word this edge
  assign out_free = !out_valid || !out_stall;
  // a byte leaves the input stage unless it is a last byte facing a full result register
  assign advance  = s1_valid && (!s1_word.is_last || out_free);
  assign in_stall = s1_valid && !advance;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word <= in_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_word.is_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_word.is_last) begin
      out_word <= result;
    end
  end

  // the pair count only goes out with a clean verdict
  `KVTV_ASSERT(a_total_ok_only, clk, rst, (out_valid && out_word.status != ST_OK) |-> (out_word.pair_total == 16'd0), "pair total with error status")
  // a waiting result is never overwritten
  `KVTV_ASSERT(a_no_overwrite, clk, rst, (out_valid && out_stall) |-> !(advance && s1_word.is_last), "result overwritten while stalled")
  // stall only when the input stage holds a byte
  `KVTV_ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> s1_valid, "stall with empty input stage")

endmodule
